FILE: design/demand_paged_memory_map_macros.svh
// Assertion macros shared by the demand-paged memory map page table and top level.
`ifndef DEMAND_PAGED_MEMORY_MAP_MACROS_SVH
`define DEMAND_PAGED_MEMORY_MAP_MACROS_SVH

`ifndef SYNTH
`define DPM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("dpm assertion failed");
`define DPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dpm assertion failed");
`else
`define DPM_ASSERT(lbl, clk, rst_n, prop)
`define DPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/dpm_pkg.sv
// Package with the constants and types of the demand-paged memory map.
`timescale 1ns / 1ps
package dpm_pkg;

	localparam int DPM_PHYSICAL_PAGES = 56;
	localparam int DPM_PAGE_BITS      = 10;

	localparam int BUS_ADDR_W  = 16;
	localparam int BYTE_W      = 8;
	localparam int CHIP_REG_W  = 5;

	localparam logic [BUS_ADDR_W-1:0] CHIP_LOW  = 16'hD400;
	localparam logic [BUS_ADDR_W-1:0] CHIP_HIGH = 16'hD800;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	// Outcome of a page table lookup for the access in stage one.
	typedef struct packed {
		logic ok;
		logic alloc;
	} dpm_xlate_t;

	// Byte store access request.
	typedef struct packed {
		logic wr;
		logic rd;
	} dpm_store_req_t;

endpackage

FILE: design/dpm_page_table.sv
// Page table with allocate-on-first-touch and forwarding of a fresh mapping.
`timescale 1ns / 1ps
`include "demand_paged_memory_map_macros.svh"
module dpm_page_table #(
	parameter int PHYSICAL_PAGES = dpm_pkg::DPM_PHYSICAL_PAGES,
	parameter int PAGE_BITS      = dpm_pkg::DPM_PAGE_BITS,
	parameter int VP_W           = dpm_pkg::BUS_ADDR_W - PAGE_BITS,
	parameter int PPN_W          = (PHYSICAL_PAGES > 1) ? $clog2(PHYSICAL_PAGES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cap,
	input  logic [VP_W-1:0]  cap_vp,
	input  logic             mem_s1,
	input  logic [VP_W-1:0]  vp_s1,
	input  logic             adv,
	output logic [PPN_W-1:0] ppn,
	output dpm_pkg::dpm_xlate_t stat
);
	import dpm_pkg::*;

	localparam int VP_N  = 1 << VP_W;
	localparam int CNT_W = $clog2(PHYSICAL_PAGES + 1);

	logic [VP_N-1:0]  valid_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PPN_W-1:0] map_mem [VP_N];
	logic [PPN_W-1:0] map_rd_q;
	logic             fwd_hit_q;
	logic [PPN_W-1:0] fwd_ppn_q;

	logic hit;
	logic avail;
	logic alloc_go;

	assign hit      = valid_q[vp_s1];
	assign avail    = cnt_q < CNT_W'(PHYSICAL_PAGES);
	assign stat.ok    = hit || avail;
	assign stat.alloc = mem_s1 && !hit && avail;
	assign alloc_go = stat.alloc && adv;

	// The registered read misses a mapping written at the edge that loaded stage one.
	assign ppn = hit ? (fwd_hit_q ? fwd_ppn_q : map_rd_q) : cnt_q[PPN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			cnt_q     <= '0;
			fwd_hit_q <= 1'b0;
		end else begin
			if (alloc_go) begin
				valid_q[vp_s1] <= 1'b1;
				cnt_q          <= cnt_q + 1'b1;
			end
			if (cap) begin
				fwd_hit_q <= alloc_go && (vp_s1 == cap_vp);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (alloc_go) begin
			map_mem[vp_s1] <= cnt_q[PPN_W-1:0];
		end
		if (cap) begin
			map_rd_q  <= map_mem[cap_vp];
			fwd_ppn_q <= cnt_q[PPN_W-1:0];
		end
	end

	`DPM_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(PHYSICAL_PAGES))
	`DPM_ASSERT_NEXT(a_alloc_count, clk, arst_n, alloc_go, cnt_q == $past(cnt_q) + 1'b1)
	`DPM_ASSERT(a_fail_only_full, clk, arst_n,
		!(mem_s1 && !stat.ok) || (cnt_q == CNT_W'(PHYSICAL_PAGES)))

endmodule

FILE: design/dpm_byte_store.sv
// Byte store memory with its clearing pass after reset.
`timescale 1ns / 1ps
module dpm_byte_store #(
	parameter int PHYSICAL_PAGES = dpm_pkg::DPM_PHYSICAL_PAGES,
	parameter int PAGE_BITS      = dpm_pkg::DPM_PAGE_BITS,
	parameter int ADDR_W         = ((PHYSICAL_PAGES > 1) ? $clog2(PHYSICAL_PAGES) : 1)
	                               + PAGE_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dpm_pkg::dpm_store_req_t    req,
	input  logic [ADDR_W-1:0]          addr,
	input  logic [dpm_pkg::BYTE_W-1:0] wdata,
	output logic                       busy,
	output logic [dpm_pkg::BYTE_W-1:0] rd_data
);
	import dpm_pkg::*;

	localparam int STORE_SIZE = PHYSICAL_PAGES << PAGE_BITS;

	logic [BYTE_W-1:0] mem [STORE_SIZE];
	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [ADDR_W-1:0] mem_addr;
	logic              mem_we;
	logic [BYTE_W-1:0] mem_wdata;

	assign busy      = clr_busy_q;
	assign mem_addr  = clr_busy_q ? clr_addr_q : addr;
	assign mem_we    = clr_busy_q || req.wr;
	assign mem_wdata = clr_busy_q ? '0 : wdata;

	// One entry a cycle is zeroed until the whole store has been swept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == ADDR_W'(STORE_SIZE - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (req.rd && !clr_busy_q) begin
			rd_data <= mem[mem_addr];
		end
	end

endmodule

FILE: design/demand_paged_memory_map.sv
// Top level of the demand-paged memory map: input stage, result stage and output.
//
//  Channel | Handshake             | Beat fields
//  req     | req_valid, req_stall  | kind, address, write_data
//  rsp     | rsp_valid, rsp_stall  | read_data, success, chip_strobe, chip_register, chip_value
//
// One beat is accepted per cycle while req_stall is low, and its result is offered on
// rsp once it has moved from stage one into the result stage.
// The page table read is registered at acceptance and the byte store read at the
// step into the result stage; a fresh mapping is forwarded to the next beat.
// After reset a clearing pass zeroes all PHYSICAL_PAGES * 2**PAGE_BITS entries
// (57344 by default) of the byte store, and req_stall stays high until it ends.
// A held rsp_stall freezes the result stage, and req_stall rises as soon as stage
// one also holds a beat.
`timescale 1ns / 1ps
`include "demand_paged_memory_map_macros.svh"
module demand_paged_memory_map #(
	parameter int PHYSICAL_PAGES = dpm_pkg::DPM_PHYSICAL_PAGES,
	parameter int PAGE_BITS      = dpm_pkg::DPM_PAGE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic                           kind,
	input  logic [dpm_pkg::BUS_ADDR_W-1:0] address,
	input  logic [dpm_pkg::BYTE_W-1:0]     write_data,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [dpm_pkg::BYTE_W-1:0]     read_data,
	output logic                           success,
	output logic                           chip_strobe,
	output logic [dpm_pkg::CHIP_REG_W-1:0] chip_register,
	output logic [dpm_pkg::BYTE_W-1:0]     chip_value
);
	import dpm_pkg::*;

	localparam int VP_W   = BUS_ADDR_W - PAGE_BITS;
	localparam int PPN_W  = (PHYSICAL_PAGES > 1) ? $clog2(PHYSICAL_PAGES) : 1;
	localparam int ADDR_W = PPN_W + PAGE_BITS;

	logic                  s1_valid_q;
	logic                  kind_s1;
	logic [BUS_ADDR_W-1:0] addr_s1;
	logic [BYTE_W-1:0]     data_s1;

	logic                  s2_valid_q;
	logic                  rzero_s2;
	logic                  success_s2;
	logic                  strobe_s2;
	logic [CHIP_REG_W-1:0] reg_s2;
	logic [BYTE_W-1:0]     val_s2;

	logic                  cap;
	logic                  adv;
	logic                  chip_s1;
	logic                  mem_s1;
	logic                  mem_go;
	logic                  strobe_go;
	logic                  clr_busy;
	logic [PPN_W-1:0]      ppn;
	dpm_xlate_t            xstat;
	dpm_store_req_t        sreq;
	logic [BYTE_W-1:0]     store_rd;

	assign adv       = s1_valid_q && (!s2_valid_q || !rsp_stall);
	assign req_stall = clr_busy || (s1_valid_q && !adv);
	assign cap       = req_valid && !req_stall;

	assign chip_s1   = (addr_s1 >= CHIP_LOW) && (addr_s1 < CHIP_HIGH);
	assign mem_s1    = s1_valid_q && !chip_s1;
	assign mem_go    = adv && mem_s1 && xstat.ok;
	assign strobe_go = chip_s1 && (kind_s1 == KIND_WRITE);

	assign sreq.wr = mem_go && (kind_s1 == KIND_WRITE);
	assign sreq.rd = mem_go && (kind_s1 == KIND_READ);

	dpm_page_table #(
		.PHYSICAL_PAGES(PHYSICAL_PAGES),
		.PAGE_BITS     (PAGE_BITS),
		.VP_W          (VP_W),
		.PPN_W         (PPN_W)
	) u_page_table (
		.clk   (clk),
		.arst_n(arst_n),
		.cap   (cap),
		.cap_vp(address[BUS_ADDR_W-1:PAGE_BITS]),
		.mem_s1(mem_s1),
		.vp_s1 (addr_s1[BUS_ADDR_W-1:PAGE_BITS]),
		.adv   (adv),
		.ppn   (ppn),
		.stat  (xstat)
	);

	dpm_byte_store #(
		.PHYSICAL_PAGES(PHYSICAL_PAGES),
		.PAGE_BITS     (PAGE_BITS),
		.ADDR_W        (ADDR_W)
	) u_byte_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.addr   ({ppn, addr_s1[PAGE_BITS-1:0]}),
		.wdata  (data_s1),
		.busy   (clr_busy),
		.rd_data(store_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (cap) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				s2_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			kind_s1 <= kind;
			addr_s1 <= address;
			data_s1 <= write_data;
		end
		if (adv) begin
			rzero_s2   <= !(mem_s1 && xstat.ok && (kind_s1 == KIND_READ));
			success_s2 <= chip_s1 || xstat.ok;
			strobe_s2  <= strobe_go;
			reg_s2     <= strobe_go ? addr_s1[CHIP_REG_W-1:0] : '0;
			val_s2     <= strobe_go ? data_s1 : '0;
		end
	end

	assign rsp_valid     = s2_valid_q;
	assign read_data     = rzero_s2 ? '0 : store_rd;
	assign success       = success_s2;
	assign chip_strobe   = strobe_s2;
	assign chip_register = reg_s2;
	assign chip_value    = val_s2;

	`DPM_ASSERT(a_clear_blocks, clk, arst_n, !clr_busy || req_stall)
	`DPM_ASSERT(a_strobe_ok, clk, arst_n, !(rsp_valid && chip_strobe) || success)
	`DPM_ASSERT(a_fail_quiet, clk, arst_n,
		!(rsp_valid && !success) || ((read_data == '0) && !chip_strobe))
	`DPM_ASSERT_NEXT(a_s1_held, clk, arst_n, s1_valid_q && !adv, s1_valid_q)

endmodule
